### rtl/dv2_percent_rank_indicator_defines.svh
// assertion macros for the percent rank block
`ifndef DV2_PERCENT_RANK_INDICATOR_DEFINES_SVH
`define DV2_PERCENT_RANK_INDICATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DV2PR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dv2pr assertion failed");
`define DV2PR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dv2pr assertion failed");
`else
`define DV2PR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DV2PR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/dv2pr_pkg.sv
package dv2pr_pkg;
	localparam int MAX_MA_PERIOD   = 16;
	localparam int MAX_RANK_PERIOD = 256;
	localparam int PRICE_BITS      = 32;
	localparam int RATIO_W         = 32;
	localparam int SUM_W           = 36;
	localparam int RP_W            = 4;
	localparam int SP_W            = 8;
	localparam int SEEN_W          = 10;
	localparam int SEEN_CAP        = MAX_MA_PERIOD + MAX_RANK_PERIOD - 1;
	localparam int DEN_W           = PRICE_BITS + 1;
	localparam int DVD_W           = DEN_W + 16;
	localparam int QUO_W           = 32;
	localparam int CNT_W           = 9;
	localparam int PCT_W           = 15;
	localparam int MA_W            = 5;
	localparam int RANK_W          = 9;
	localparam int DIV_STEPS       = DVD_W;
	localparam int STEP_W          = 6;
	localparam logic [15:0] PCT_SCALE = 16'd25600;
	localparam logic [RATIO_W-1:0] RATIO_ONE = 32'h0001_0000;
	localparam logic [RATIO_W-1:0] RATIO_MAX = 32'hFFFF_FFFF;
	localparam logic [MA_W-1:0]   MA_RESET   = 5'd2;
	localparam logic [RANK_W-1:0] RANK_RESET = 9'd252;
	localparam logic REG_MA   = 1'b0;
	localparam logic REG_RANK = 1'b1;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;
endpackage

### rtl/dv2_percent_rank_indicator.sv
// DV2 percent rank: one bar per request, one result per bar. A full bar passes,
// from request to output register, through two 49-step radix-2 divides
// (ratio and percent) on one shared divider, one read per cycle of the ratio
// ring to form the moving sum, and one read per cycle of the 256-entry
// smoothed ring to count entries below the newest. Bars with a zero
// high-plus-low sum or a saturated ratio skip the first divide, and
// bars still warming up skip the scan and the second divide. The next
// request is taken once the current bar has been handed to the output
// register. No clearing pass follows reset: a fill count marks smoothed
// slots not yet written since reset or restart, and those read as zero.
`include "dv2_percent_rank_indicator_defines.svh"
module dv2_percent_rank_indicator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        restart,
	input  logic [31:0] high_price,
	input  logic [31:0] low_price,
	input  logic [31:0] close_price,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valid_res,
	output logic [7:0]  count_below,
	output logic [14:0] rank_percent,
	output logic        ratio_saturated
);
	import dv2pr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RATIO, ST_RDIV, ST_WRR, ST_SUM, ST_WRS,
		ST_SCAN, ST_PDIV, ST_FIN
	} state_t;

	state_t state_q;
	logic [MA_W-1:0]    ma_q;
	logic [RANK_W-1:0]  rank_q;
	logic [MA_W-1:0]    ma_eff;
	logic [RANK_W-1:0]  rank_eff;
	logic [RP_W-1:0]    rp_q;
	logic [SP_W-1:0]    sp_q;
	logic [CNT_W-1:0]   fill_q;
	logic [SEEN_W-1:0]  seen_q;
	logic [SEEN_W-1:0]  seen_nx;
	logic [SEEN_W-1:0]  warm;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   num_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               sat_q;
	logic [SUM_W-1:0]   acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   k_q;
	logic               rd_vld_s1;
	logic               live_s1;
	logic               res_valid_q;
	logic [PCT_W-1:0]   pct_q;
	logic               issue;
	logic               ratio_ovf;
	logic               div_go;
	logic               out_load;
	logic               cfg_wr;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic [RATIO_W-1:0] rr_rdata;
	logic [SUM_W-1:0]   sr_rdata;
	logic [RP_W-1:0]    rr_raddr;
	logic [SP_W-1:0]    sr_raddr;
	logic               out_valid_q;
	logic               vres_q;
	logic [7:0]         cnt_out_q;
	logic [PCT_W-1:0]   pct_out_q;
	logic               sat_out_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_RANK) ? {23'd0, rank_q} : {27'd0, ma_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ma_q   <= MA_RESET;
			rank_q <= RANK_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MA:   ma_q <= pwdata[MA_W-1:0];
				REG_RANK: rank_q <= pwdata[RANK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ma_q == '0) ma_eff = MA_W'(1);
		else if (ma_q > MA_W'(MAX_MA_PERIOD)) ma_eff = MA_W'(MAX_MA_PERIOD);
		else ma_eff = ma_q;
		if (rank_q == '0) rank_eff = RANK_W'(1);
		else if (rank_q > RANK_W'(MAX_RANK_PERIOD)) rank_eff = RANK_W'(MAX_RANK_PERIOD);
		else rank_eff = rank_q;
	end

	assign seen_nx   = (seen_q < SEEN_W'(SEEN_CAP)) ? seen_q + 1'b1 : seen_q;
	assign warm      = SEEN_W'(ma_eff) + SEEN_W'(rank_eff) - 1'b1;
	assign issue     = (state_q == ST_SUM) ? (k_q < CNT_W'(ma_eff)) : (k_q < rank_eff);
	assign rr_raddr  = rp_q - 1'b1 - k_q[RP_W-1:0];
	assign sr_raddr  = sp_q - 1'b1 - k_q[SP_W-1:0];
	assign in_ready  = (state_q == ST_IDLE);
	assign ratio_ovf = ({16'd0, num_q} >= {den_q, 16'd0});
	assign div_go    = ((state_q == ST_RATIO) && (den_q != '0) && !ratio_ovf) ||
		((state_q == ST_SCAN) && !issue && !rd_vld_s1);
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	dv2pr_ram #(.DEPTH(MAX_MA_PERIOD), .WIDTH(RATIO_W)) u_ratio_ring (
		.clk   (clk),
		.we    (state_q == ST_WRR),
		.waddr (rp_q),
		.wdata (ratio_q),
		.raddr (rr_raddr),
		.rdata (rr_rdata)
	);

	dv2pr_ram #(.DEPTH(MAX_RANK_PERIOD), .WIDTH(SUM_W)) u_smoothed_ring (
		.clk   (clk),
		.we    (state_q == ST_WRS),
		.waddr (sp_q),
		.wdata (acc_q),
		.raddr (sr_raddr),
		.rdata (sr_rdata)
	);

	dv2pr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rp_q          <= '0;
			sp_q          <= '0;
			fill_q        <= '0;
			seen_q        <= '0;
			rd_vld_s1     <= 1'b0;
			div_req.start <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			div_req.start <= div_go;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (restart) begin
							rp_q   <= '0;
							sp_q   <= '0;
							fill_q <= '0;
							seen_q <= '0;
						end
						den_q   <= DEN_W'(high_price) + DEN_W'(low_price);
						num_q   <= {close_price, 1'b0};
						state_q <= ST_RATIO;
					end
				end
				ST_RATIO: begin
					sat_q <= (den_q != '0) && ratio_ovf;
					if (den_q == '0) begin
						ratio_q <= RATIO_ONE;
						state_q <= ST_WRR;
					end else if (ratio_ovf) begin
						ratio_q <= RATIO_MAX;
						state_q <= ST_WRR;
					end else begin
						div_req.dividend <= {num_q, 16'd0};
						div_req.divisor  <= den_q;
						state_q          <= ST_RDIV;
					end
				end
				ST_RDIV: begin
					if (div_rsp.done) begin
						ratio_q <= div_rsp.quotient;
						state_q <= ST_WRR;
					end
				end
				ST_WRR: begin
					rp_q      <= rp_q + 1'b1;
					seen_q    <= seen_nx;
					k_q       <= '0;
					acc_q     <= '0;
					cnt_q     <= '0;
					pct_q     <= '0;
					rd_vld_s1 <= 1'b0;
					if (seen_nx >= SEEN_W'(ma_eff)) begin
						state_q <= ST_SUM;
					end else begin
						res_valid_q <= 1'b0;
						state_q     <= ST_FIN;
					end
				end
				ST_SUM: begin
					rd_vld_s1 <= issue;
					if (issue) k_q <= k_q + 1'b1;
					if (rd_vld_s1) acc_q <= acc_q + SUM_W'(rr_rdata);
					if (!issue && !rd_vld_s1) state_q <= ST_WRS;
				end
				ST_WRS: begin
					sp_q      <= sp_q + 1'b1;
					if (fill_q != CNT_W'(MAX_RANK_PERIOD)) fill_q <= fill_q + 1'b1;
					k_q       <= '0;
					rd_vld_s1 <= 1'b0;
					if (seen_q >= warm) begin
						state_q <= ST_SCAN;
					end else begin
						res_valid_q <= 1'b0;
						state_q     <= ST_FIN;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= issue;
					live_s1   <= (k_q < fill_q);
					if (issue) k_q <= k_q + 1'b1;
					// slots not written since reset or restart count as zero
					if (rd_vld_s1 && (live_s1 ? (sr_rdata < acc_q) : (acc_q != '0)))
						cnt_q <= cnt_q + 1'b1;
					if (!issue && !rd_vld_s1) begin
						div_req.dividend <= DVD_W'(cnt_q) * DVD_W'(PCT_SCALE);
						div_req.divisor  <= DEN_W'(rank_eff);
						state_q          <= ST_PDIV;
					end
				end
				ST_PDIV: begin
					if (div_rsp.done) begin
						pct_q       <= div_rsp.quotient[PCT_W-1:0];
						res_valid_q <= 1'b1;
						state_q     <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						vres_q    <= res_valid_q;
						cnt_out_q <= cnt_q[7:0];
						pct_out_q <= pct_q;
						sat_out_q <= sat_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign valid_res       = vres_q;
	assign count_below     = cnt_out_q;
	assign rank_percent    = pct_out_q;
	assign ratio_saturated = sat_out_q;

	`DV2PR_ASSERT_NXT(a_one_bar, clk, arst_n, in_valid && in_ready, !in_ready)
	`DV2PR_ASSERT_IMP(a_pct_range, clk, arst_n, out_valid && valid_res,
		rank_percent <= PCT_W'(25600))
	`DV2PR_ASSERT_IMP(a_nan_zero, clk, arst_n, out_valid && !valid_res,
		count_below == 8'd0 && rank_percent == '0)
	`DV2PR_ASSERT_IMP(a_div_wait, clk, arst_n, div_rsp.done,
		state_q == ST_RDIV || state_q == ST_PDIV)
endmodule

### rtl/dv2pr_ram.sv
module dv2pr_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/dv2pr_div.sv
module dv2pr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  dv2pr_pkg::div_req_t req,
	output dv2pr_pkg::div_rsp_t rsp
);
	import dv2pr_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DVD_W-1:0]  dq_q;
	logic [DEN_W:0]    trial;
	logic              qbit;

	always_comb begin
		trial = {rem_q, dq_q[DVD_W-1]};
		qbit  = (trial >= {1'b0, den_q});
		if (qbit) begin
			trial = trial - {1'b0, den_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (step_q == STEP_W'(DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				rem_q  <= '0;
				den_q  <= req.divisor;
				dq_q   <= req.dividend;
			end else if (busy_q) begin
				rem_q <= trial[DEN_W-1:0];
				dq_q  <= {dq_q[DVD_W-2:0], qbit};
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q[QUO_W-1:0];
endmodule

### sim/tb_dv2_percent_rank_indicator.sv
module tb_dv2_percent_rank_indicator;
	timeunit 1ns;
	timeprecision 1ps;
	import dv2pr_pkg::*;

	localparam logic [2:0] ADDR_MA   = {1'b0, REG_MA, 2'b00};
	localparam logic [2:0] ADDR_RANK = {1'b0, REG_RANK, 2'b00};
	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		logic             valid_res;
		logic [7:0]       count_below;
		logic [PCT_W-1:0] rank_percent;
		logic             ratio_saturated;
	} rank_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	logic restart = 1'b0;
	logic [31:0] high_price = '0, low_price = '0, close_price = '0;
	logic out_valid, out_ready = 1'b0;
	logic valid_res, ratio_saturated;
	logic [7:0] count_below;
	logic [14:0] rank_percent;

	dv2_percent_rank_indicator dut (.*);

	always #2 clk = ~clk;

	// predictor state
	logic [MA_W-1:0]   ma_reg;
	logic [RANK_W-1:0] rank_reg;
	logic [RATIO_W-1:0] ratio_hist [MAX_MA_PERIOD];
	logic [SUM_W-1:0]   sum_hist [MAX_RANK_PERIOD];
	int ratio_wr, sum_wr, seen;

	rank_result_t rank_queue [$];
	int err_count = 0;
	int cycles = 0;
	bit no_idle = 0;
	bit hold_go = 0;

	function automatic int clamp_len(int v, int top);
		if (v == 0) return 1;
		return (v > top) ? top : v;
	endfunction

	function automatic void clear_hist();
		foreach (ratio_hist[i]) ratio_hist[i] = '0;
		foreach (sum_hist[i]) sum_hist[i] = '0;
		ratio_wr = 0;
		sum_wr = 0;
		seen = 0;
	endfunction

	function automatic rank_result_t predict_rank(logic rs, logic [31:0] h, logic [31:0] l,
			logic [31:0] c);
		rank_result_t r;
		int ma, rank, cnt;
		logic [63:0] num, den, q;
		logic [RATIO_W-1:0] ratio;
		logic [SUM_W-1:0] sum;
		ma = clamp_len(ma_reg, MAX_MA_PERIOD);
		rank = clamp_len(rank_reg, MAX_RANK_PERIOD);
		r = '0;
		cnt = 0;
		if (rs) clear_hist();
		den = 64'(h) + 64'(l);
		num = 64'(c) << 1;
		if (den == 0) begin
			ratio = RATIO_ONE;
		end else if (num / den >= 64'd65536) begin
			ratio = RATIO_MAX;
			r.ratio_saturated = 1'b1;
		end else begin
			q = (num << 16) / den;
			ratio = q[31:0];
		end
		ratio_hist[ratio_wr] = ratio;
		ratio_wr = (ratio_wr + 1) % MAX_MA_PERIOD;
		if (seen < SEEN_CAP) seen++;
		if (seen >= ma) begin
			sum = '0;
			for (int k = 1; k <= ma; k++)
				sum += ratio_hist[(ratio_wr + MAX_MA_PERIOD - k) % MAX_MA_PERIOD];
			sum_hist[sum_wr] = sum;
			sum_wr = (sum_wr + 1) % MAX_RANK_PERIOD;
			if (seen >= ma + rank - 1) begin
				r.valid_res = 1'b1;
				for (int k = 1; k <= rank; k++)
					if (sum_hist[(sum_wr + MAX_RANK_PERIOD - k) % MAX_RANK_PERIOD] < sum)
						cnt++;
				r.count_below = cnt[7:0];
				r.rank_percent = PCT_W'((cnt * 25600) / rank);
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[dv2_percent_rank_indicator] ERROR");
			$finish;
		end
	end

	// receiver with random stalls and one long hold-off
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);
		end
	end

	always @(posedge clk) begin
		rank_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (rank_queue.size() == 0) begin
				$error("result with no request waiting");
				err_count++;
			end else begin
				e = rank_queue.pop_front();
				if (valid_res !== e.valid_res) begin
					$error("valid_res exp %0d got %0d", e.valid_res, valid_res);
					err_count++;
				end
				if (count_below !== e.count_below) begin
					$error("count_below exp %0d got %0d", e.count_below, count_below);
					err_count++;
				end
				if (rank_percent !== e.rank_percent) begin
					$error("rank_percent exp %0d got %0d", e.rank_percent, rank_percent);
					err_count++;
				end
				if (ratio_saturated !== e.ratio_saturated) begin
					$error("ratio_saturated exp %0d got %0d", e.ratio_saturated,
						ratio_saturated);
					err_count++;
				end
			end
		end
	end

	task automatic send_bar(logic rs, logic [31:0] h, logic [31:0] l, logic [31:0] c);
		int gap;
		gap = (!no_idle && $urandom_range(99) < 12) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		high_price <= h;
		low_price <= l;
		close_price <= c;
		do @(posedge clk); while (!in_ready);
		rank_queue = {rank_queue, predict_rank(rs, h, l, c)};
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (rank_queue.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_MA) ma_reg = data[MA_W-1:0];
		else rank_reg = data[RANK_W-1:0];
	endtask

	task automatic set_periods(logic [31:0] ma, logic [31:0] rank);
		wait_drained();
		write_reg(ADDR_MA, ma);
		write_reg(ADDR_RANK, rank);
	endtask

	task automatic random_bar(logic rs);
		logic [31:0] base, spread, h, l, c;
		int kind;
		kind = $urandom_range(99);
		base = $urandom() >> $urandom_range(0, 24);
		spread = base >> $urandom_range(3, 12);
		l = base;
		h = base + $urandom_range(0, spread);
		c = l + $urandom_range(0, h - l);
		if (kind < 15) begin
			h = $urandom();
			l = $urandom();
			c = $urandom();
		end else if (kind < 20) begin
			h = '0;
			l = '0;
			c = $urandom();
		end else if (kind < 25) begin
			h = $urandom_range(0, 3);
			l = $urandom_range(0, 3);
			c = $urandom() | 32'h8000_0000;
		end
		send_bar(rs, h, l, c);
	endtask

	task automatic run_series(int n);
		random_bar(1'b1);
		for (int i = 1; i < n; i++)
			random_bar($urandom_range(199) == 0);
	endtask

	task automatic test_directed();
		send_bar(1'b0, 32'd0, 32'd0, 32'd0);
		send_bar(1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send_bar(1'b0, 32'd0, 32'd1, 32'hFFFF_FFFF);
		send_bar(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_bar(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_bar(1'b0, 32'd1, 32'd1, 32'd65536);
		send_bar(1'b0, 32'd1, 32'd1, 32'd65535);
		send_bar(1'b1, 32'd3, 32'd0, 32'd7);
		send_bar(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000);
		send_bar(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
		set_periods(32'd1, 32'd1);
		send_bar(1'b1, 32'd10, 32'd10, 32'd10);
		send_bar(1'b0, 32'd10, 32'd10, 32'd12);
		send_bar(1'b0, 32'd0, 32'd0, 32'd1);
		set_periods(32'd2, 32'd2);
		send_bar(1'b1, 32'd10, 32'd10, 32'd10);
		send_bar(1'b0, 32'd10, 32'd10, 32'd11);
		send_bar(1'b0, 32'd10, 32'd10, 32'd9);
		send_bar(1'b0, 32'd10, 32'd10, 32'd20);
		send_bar(1'b0, 32'd10, 32'd10, 32'd20);
	endtask

	task automatic test_reset_periods();
		set_periods(32'(MA_RESET), 32'(RANK_RESET));
		run_series(330);
	endtask

	task automatic test_shortest();
		set_periods(32'd1, 32'd1);
		run_series(100);
	endtask

	task automatic test_longest();
		set_periods(32'd16, 32'd256);
		run_series(320);
	endtask

	task automatic test_out_of_range();
		set_periods(32'd0, 32'd0);
		run_series(50);
		set_periods(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_series(290);
	endtask

	task automatic test_backpressure();
		set_periods(32'd3, 32'd5);
		run_series(40);
		hold_go = 1;
		run_series(160);
	endtask

	task automatic test_no_idle();
		set_periods(32'd7, 32'd30);
		no_idle = 1;
		run_series(150);
		no_idle = 0;
	endtask

	initial begin
		ma_reg = MA_RESET;
		rank_reg = RANK_RESET;
		clear_hist();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_reset_periods();
		test_shortest();
		test_longest();
		test_out_of_range();
		test_backpressure();
		test_no_idle();
		in_valid <= 1'b0;
		while (rank_queue.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (err_count == 0)
			$display("[dv2_percent_rank_indicator] OK");
		else
			$display("[dv2_percent_rank_indicator] ERROR");
		$finish;
	end
endmodule
